### design/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants for the text prime counter: default widths, character
// codes of the token parser and the first trial divisor.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int COUNT_BITS_DEF = 32;
  localparam int OUT_BITS       = 32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int FIRST_DIVISOR = 2;

endpackage

### design/tpc_divider.sv
// ----------------------------------------------------------------------------
// tpc_divider
// Restoring divider, one quotient bit per cycle. Gives quotient and
// remainder of an unsigned division after VALUE_BITS steps.
// ----------------------------------------------------------------------------
module tpc_divider #(
  parameter int VALUE_BITS = tpc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder
);
  import tpc_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic [CNT_W-1:0]      steps;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   rem_diff;
  logic                  fits;
  logic [VALUE_BITS-1:0] rem_next;
  logic [VALUE_BITS-1:0] quo_next;

  always_comb begin
    rem_shift = {rem, quo[VALUE_BITS-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = (rem_shift >= {1'b0, divisor});
    rem_next  = fits ? rem_diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
    quo_next  = {quo[VALUE_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### design/text_prime_counter_unit.sv
// ----------------------------------------------------------------------------
// text_prime_counter_unit
// Counts the prime decimal tokens of a byte stream and reports the count at
// each end of file.
// ----------------------------------------------------------------------------
// usage:
//   input channel: text_byte plus end_of_file, one request per file byte,
//   taken when in_valid is high and in_stall is low. tokens are split by
//   space, tab, cr and lf and read like atoi with a saturating magnitude.
//   output channel: prime_total, one request for each byte flagged
//   end_of_file, held in an output register until out_stall is low.
//   a byte that closes no testable token goes straight to the last step. a
//   token value n >= 2 is tested by trial division with divisors 2 and then
//   the odd numbers from 3, while divisor <= n / divisor; each divisor takes
//   one run of the bit-serial divider, and for a prime n the number of
//   divisors tried is about sqrt(n) / 2 + 1.5.
//   in_stall stays high while a test runs; the loop has a single divider,
//   and an adder steps the trial divisor.
//   an end of file byte waits in the last step while a previous total is
//   still stalled in the output register.
//   reset clears the token state, the count and the output valid.
// ----------------------------------------------------------------------------
module text_prime_counter_unit #(
  parameter int VALUE_BITS = tpc_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = tpc_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   text_byte,
  input  logic                         end_of_file,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tpc_pkg::OUT_BITS-1:0] prime_total
);
  import tpc_pkg::*;

  localparam int SUM_W = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // token parser state
  logic [VALUE_BITS-1:0] token_value;
  logic                  token_negative;
  logic                  inside_token;
  logic                  digits_stopped;
  logic [COUNT_BITS-1:0] running_count;

  // test in flight
  logic [VALUE_BITS-1:0] test_value;
  logic [VALUE_BITS-1:0] trial_divisor;
  logic                  found_prime;
  logic                  eof_pending;

  logic                  accept;
  logic                  is_sep;
  logic                  is_digit;
  logic [SUM_W-1:0]      value_ext;
  logic [SUM_W-1:0]      digit_sum;
  logic [VALUE_BITS-1:0] digit_value;
  logic [VALUE_BITS-1:0] value_next;
  logic                  negative_next;
  logic                  inside_next;
  logic                  stopped_next;
  logic                  need_test;
  logic [COUNT_BITS-1:0] count_next;
  logic                  out_free;
  logic                  out_load;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quotient;
  logic [VALUE_BITS-1:0] div_remainder;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_FINISH) && eof_pending && out_free;

  assign is_sep   = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                    (text_byte == CH_CR) || (text_byte == CH_LF);
  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);

  // value * 10 + digit, saturating
  always_comb begin
    value_ext = SUM_W'(token_value);
    digit_sum = (value_ext << 3) + (value_ext << 1) + SUM_W'(text_byte - CH_ZERO);
    if (digit_sum > SUM_W'(VALUE_MAX)) begin
      digit_value = VALUE_MAX;
    end else begin
      digit_value = digit_sum[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    value_next    = token_value;
    negative_next = token_negative;
    inside_next   = inside_token;
    stopped_next  = digits_stopped;
    if (is_sep) begin
      // token closes below
    end else if (!inside_token) begin
      if ((text_byte == CH_VT) || (text_byte == CH_FF)) begin
        // leading white space is skipped
      end else begin
        inside_next = 1'b1;
        if (text_byte == CH_MINUS) begin
          negative_next = 1'b1;
        end else if (text_byte == CH_PLUS) begin
          // plus sign only
        end else if (is_digit) begin
          value_next = digit_value;
        end else begin
          stopped_next = 1'b1;
        end
      end
    end else if (!digits_stopped) begin
      if (is_digit) begin
        value_next = digit_value;
      end else begin
        stopped_next = 1'b1;
      end
    end
    need_test = (is_sep || end_of_file) && inside_next && !negative_next &&
                (value_next >= VALUE_BITS'(FIRST_DIVISOR));
  end

  assign count_next = (found_prime && (running_count != COUNT_MAX)) ?
                      running_count + COUNT_BITS'(1) : running_count;

  assign div_start = (state == S_START);

  tpc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (test_value),
    .divisor   (trial_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      token_value    <= '0;
      token_negative <= 1'b0;
      inside_token   <= 1'b0;
      digits_stopped <= 1'b0;
      running_count  <= '0;
      found_prime    <= 1'b0;
      eof_pending    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            found_prime <= 1'b0;
            eof_pending <= end_of_file;
            if (is_sep || end_of_file) begin
              token_value    <= '0;
              token_negative <= 1'b0;
              inside_token   <= 1'b0;
              digits_stopped <= 1'b0;
            end else begin
              token_value    <= value_next;
              token_negative <= negative_next;
              inside_token   <= inside_next;
              digits_stopped <= stopped_next;
            end
            state <= need_test ? S_START : S_FINISH;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            if (div_quotient < trial_divisor) begin
              found_prime <= 1'b1;
              state       <= S_FINISH;
            end else if (div_remainder == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_START;
            end
          end
        end
        S_FINISH: begin
          if (!eof_pending) begin
            running_count <= count_next;
            state         <= S_IDLE;
          end else if (out_free) begin
            running_count <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // operand registers of the trial loop
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && accept) begin
      test_value    <= value_next;
      trial_divisor <= VALUE_BITS'(FIRST_DIVISOR);
    end else if ((state == S_WAIT) && div_done) begin
      // 2, then odd divisors only
      if (trial_divisor == VALUE_BITS'(FIRST_DIVISOR)) begin
        trial_divisor <= trial_divisor + VALUE_BITS'(1);
      end else begin
        trial_divisor <= trial_divisor + VALUE_BITS'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      prime_total <= OUT_BITS'(count_next);
    end
  end

endmodule

### design/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks of the text prime counter, bound to the top level.
// ----------------------------------------------------------------------------
module tpc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [7:0]                   text_byte,
  input logic                         end_of_file,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tpc_pkg::OUT_BITS-1:0] prime_total
);
  import tpc_pkg::*;

  logic accept_in;
  assign accept_in = in_valid && !in_stall;

  // a stalled total holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prime_total))
    else $error("stalled total changed or dropped");

  // every request makes the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept_in |=> in_stall)
    else $error("input taken again right after a request");

  // a stalled request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(text_byte) && $stable(end_of_file))
    else $error("stalled request changed or dropped");

  // a total is launched only from a busy cycle
  a_total_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("total appeared while the block was idle");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind text_prime_counter_unit tpc_checker u_tpc_checker (.*);
